### hw/rtl/iira_pkg.sv
// ----------------------------------------------------------------------------
// iira_pkg: shared types and constants
// Field widths, action and status codes, the request and response payloads
// and the command that steps every cell of the word chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iira_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_INSERT    = 2'd0,
    ACT_REMOVE    = 2'd1,
    ACT_READ      = 2'd2,
    ACT_OVERWRITE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_e;

  typedef struct packed {
    action_e                   action;
    logic [CNT_W-1:0]          index;
    logic                      at_end;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    status_e                   status;
    logic [CNT_W-1:0]          entry_count;
  } rsp_t;

  typedef struct packed {
    cell_op_e                  op;
    logic [CNT_W-1:0]          pos;
    logic signed [DATA_W-1:0]  word;
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                 cmd;
    status_e                   status;
    logic                      take;
    logic [CNT_W-1:0]          next_cnt;
  } ctrl_t;

endpackage

### hw/rtl/indexed_insert_remove_array_top.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_top: ordered word list with indexed insert/remove
// Each input transfer's response is registered in the output register in the next
// cycle. Throughput: one request per cycle; every cell of the chain shifts in the
// same cycle. Input stalls only while the output register is full and out_ready_i is low.
// Reset: asynchronous, clears the entry count, every cell and the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_insert_remove_array_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  iira_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output iira_pkg::rsp_t   out_rsp_o
);
  import iira_pkg::*;

  logic                      accept;
  logic [CNT_W-1:0]          cnt_d, cnt_q;
  logic                      out_valid_d, out_valid_q;
  rsp_t                      rsp_d, rsp_q;
  ctrl_t                     ctrl;
  cell_cmd_t                 cell_cmd;
  logic signed [DATA_W-1:0]  cell_data [DEPTH];
  logic signed [DATA_W-1:0]  rd_word;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  iira_ctrl u_ctrl (
    .cur_req_i (in_req_i),
    .cnt_i     (cnt_q),
    .ctrl_o    (ctrl)
  );

  always_comb begin
    cell_cmd = ctrl.cmd;
    if (!accept) begin
      cell_cmd.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    iira_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (CNT_W'(i)),
      .cmd_i   (cell_cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  // The position is only used when it lies below the count.
  assign rd_word = cell_data[ctrl.cmd.pos[IDX_W-1:0]];

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rsp_d       = rsp_q;
    if (accept) begin
      cnt_d              = ctrl.next_cnt;
      out_valid_d        = 1'b1;
      rsp_d.result_value = ctrl.take ? rd_word : '0;
      rsp_d.status       = ctrl.status;
      rsp_d.entry_count  = ctrl.next_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_rsp_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.entry_count == cnt_q))
    else $error("response count differs from stored count");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != ST_OK)) |-> (out_rsp_o.result_value == '0))
    else $error("error response carries a nonzero word");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(cnt_q))
    else $error("entry count changed without a transfer");

  a_resp_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no response");

endmodule

### hw/rtl/iira_cell.sv
// ----------------------------------------------------------------------------
// iira_cell: one word of the chain
// Holds one entry and takes its left neighbor on insert, its right neighbor
// on remove, or the request word when it sits at the addressed position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iira_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [iira_pkg::CNT_W-1:0]        idx_i,
  input  iira_pkg::cell_cmd_t               cmd_i,
  input  logic signed [iira_pkg::DATA_W-1:0] left_i,
  input  logic signed [iira_pkg::DATA_W-1:0] right_i,
  output logic signed [iira_pkg::DATA_W-1:0] data_o
);
  import iira_pkg::*;

  logic signed [DATA_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (idx_i > cmd_i.pos) begin
          data_d = left_i;
        end else if (idx_i == cmd_i.pos) begin
          data_d = cmd_i.word;
        end
      end
      // Cells past the count hold zero, so pulling from the right also
      // clears the cell that the removal frees.
      CELL_REMOVE: begin
        if (idx_i >= cmd_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_WRITE: begin
        if (idx_i == cmd_i.pos) begin
          data_d = cmd_i.word;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### hw/rtl/iira_ctrl.sv
// ----------------------------------------------------------------------------
// iira_ctrl: request decoder
// Checks a request against the entry count, picks the position and status
// and builds the command that the cell chain executes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iira_ctrl (
  input  iira_pkg::req_t                cur_req_i,
  input  logic [iira_pkg::CNT_W-1:0]    cnt_i,
  output iira_pkg::ctrl_t               ctrl_o
);
  import iira_pkg::*;

  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CntOne  = CNT_W'(1);

  always_comb begin
    ctrl_o.cmd.op    = CELL_HOLD;
    ctrl_o.cmd.pos   = cur_req_i.index;
    ctrl_o.cmd.word  = cur_req_i.value;
    ctrl_o.status    = ST_OK;
    ctrl_o.take      = 1'b0;
    ctrl_o.next_cnt  = cnt_i;
    case (cur_req_i.action)
      ACT_INSERT: begin
        if (cur_req_i.at_end) begin
          ctrl_o.cmd.pos = cnt_i;
        end
        // The gap check wins over the full check.
        if (!cur_req_i.at_end && (cur_req_i.index > cnt_i)) begin
          ctrl_o.status = ST_RANGE;
        end else if (cnt_i >= CntFull) begin
          ctrl_o.status = ST_FULL;
        end else begin
          ctrl_o.cmd.op   = CELL_INSERT;
          ctrl_o.next_cnt = cnt_i + CntOne;
        end
      end
      ACT_REMOVE: begin
        if (cur_req_i.at_end) begin
          ctrl_o.cmd.pos = cnt_i - CntOne;
        end
        if (cur_req_i.at_end && (cnt_i == '0)) begin
          ctrl_o.status = ST_EMPTY;
        end else if (!cur_req_i.at_end && (cur_req_i.index >= cnt_i)) begin
          ctrl_o.status = ST_RANGE;
        end else begin
          ctrl_o.cmd.op   = CELL_REMOVE;
          ctrl_o.take     = 1'b1;
          ctrl_o.next_cnt = cnt_i - CntOne;
        end
      end
      ACT_READ: begin
        if (cur_req_i.index >= cnt_i) begin
          ctrl_o.status = ST_RANGE;
        end else begin
          ctrl_o.take = 1'b1;
        end
      end
      default: begin
        if (cur_req_i.index >= cnt_i) begin
          ctrl_o.status = ST_RANGE;
        end else begin
          ctrl_o.cmd.op = CELL_WRITE;
          ctrl_o.take   = 1'b1;
        end
      end
    endcase
  end

endmodule

### bench/iira_checker.sv
// ----------------------------------------------------------------------------
// iira_checker: response predictor and scoreboard for the word list
// Watches both channels of indexed_insert_remove_array_top. Each accepted
// request is applied to a local copy of the cells and the entry count. The
// expected response is queued and compared field by field with the next
// response transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iira_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  iira_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  iira_pkg::rsp_t out_rsp_i,
  output int             mismatches_o,
  output int             pending_o,
  output int             fill_level_o
);
  import iira_pkg::*;

  logic signed [DATA_W-1:0] model_cells [DEPTH];
  int                       model_count;
  rsp_t                     expected_rsps [$];
  rsp_t                     oldest;
  int                       fail_total;

  task automatic flag_mismatch(input string msg);
    fail_total++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Applies one request to the local list and returns the response it earns.
  function automatic rsp_t apply_request(input req_t req);
    rsp_t rsp;
    int   pos;
    int   j;
    rsp.result_value = '0;
    rsp.status       = ST_OK;
    case (req.action)
      ACT_INSERT: begin
        pos = req.at_end ? model_count : int'(req.index);
        // The gap is checked before the capacity.
        if (pos > model_count) begin
          rsp.status = ST_RANGE;
        end else if (model_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          for (j = model_count; j > pos; j--) model_cells[j] = model_cells[j-1];
          model_cells[pos] = req.value;
          model_count++;
        end
      end
      ACT_REMOVE: begin
        if (req.at_end && model_count == 0) begin
          rsp.status = ST_EMPTY;
        end else if (!req.at_end && int'(req.index) >= model_count) begin
          rsp.status = ST_RANGE;
        end else begin
          pos = req.at_end ? model_count - 1 : int'(req.index);
          rsp.result_value = model_cells[pos];
          for (j = pos; j + 1 < model_count; j++) model_cells[j] = model_cells[j+1];
          model_cells[model_count-1] = '0;
          model_count--;
        end
      end
      ACT_READ: begin
        if (int'(req.index) >= model_count) begin
          rsp.status = ST_RANGE;
        end else begin
          rsp.result_value = model_cells[req.index];
        end
      end
      default: begin
        if (int'(req.index) >= model_count) begin
          rsp.status = ST_RANGE;
        end else begin
          rsp.result_value = model_cells[req.index];
          model_cells[req.index] = req.value;
        end
      end
    endcase
    rsp.entry_count = CNT_W'(model_count);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (model_cells[k]) model_cells[k] = '0;
      model_count = 0;
      fail_total  = 0;
      expected_rsps.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
      fill_level_o <= 0;
    end else begin
      // A response never belongs to the request taken at the same edge,
      // so the output side is handled first.
      if (out_valid_i && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          flag_mismatch($sformatf("unexpected response: value %0d status %0d count %0d",
                                  out_rsp_i.result_value, out_rsp_i.status,
                                  out_rsp_i.entry_count));
        end else begin
          oldest = expected_rsps.pop_front();
          if (out_rsp_i.result_value !== oldest.result_value)
            flag_mismatch($sformatf("result_value got %0d want %0d",
                                    out_rsp_i.result_value, oldest.result_value));
          if (out_rsp_i.status !== oldest.status)
            flag_mismatch($sformatf("status got %0d want %0d",
                                    out_rsp_i.status, oldest.status));
          if (out_rsp_i.entry_count !== oldest.entry_count)
            flag_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_rsp_i.entry_count, oldest.entry_count));
        end
      end
      if (in_valid_i && in_ready_i) expected_rsps.push_back(apply_request(in_req_i));
      mismatches_o <= fail_total;
      pending_o    <= expected_rsps.size();
      fill_level_o <= model_count;
    end
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for indexed_insert_remove_array_top
// Drives a directed run over the empty, full and out-of-range cases, a long
// receiver hold-off, then random fill, drain and mixed bursts under four
// idling mixes. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import iira_pkg::*;

  localparam int LIMIT      = 200000;
  localparam int LONG_HOLD  = 60;
  localparam int PHASE_REQS = 150;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  int mismatches;
  int pending;
  int fill_level;
  int cycles = 0;

  int send_idle_pct;
  int recv_stall_pct;
  int ins_weight;
  int rem_weight;

  logic hold_req;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int   phase;
  int   sent;
  int   burst;
  int   k;
  req_t r;

  indexed_insert_remove_array_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  iira_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_i    (out_rsp_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .fill_level_o (fill_level)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: a toggle of hold_req starts a long hold-off counted here.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic req_t make_req(input action_e act, input int idx, input logic at_end,
                                    input logic [DATA_W-1:0] value);
    req_t q;
    q.action = act;
    q.index  = CNT_W'(idx);
    q.at_end = at_end;
    q.value  = value;
    return q;
  endfunction

  function automatic req_t random_request();
    req_t q;
    int   roll;
    roll = $urandom_range(99);
    if (roll < ins_weight) begin
      q.action = ACT_INSERT;
    end else if (roll < ins_weight + rem_weight) begin
      q.action = ACT_REMOVE;
    end else if ($urandom_range(1) == 0) begin
      q.action = ACT_READ;
    end else begin
      q.action = ACT_OVERWRITE;
    end
    // Mostly positions near the current fill, now and then anywhere in the field.
    if ($urandom_range(99) < 12) q.index = CNT_W'($urandom_range(31));
    else q.index = CNT_W'($urandom_range(fill_level));
    q.at_end = ($urandom_range(99) < 25);
    case ($urandom_range(7))
      0:       q.value = 32'h7fff_ffff;
      1:       q.value = 32'h8000_0000;
      2:       q.value = '0;
      3:       q.value = '1;
      default: q.value = $urandom;
    endcase
    return q;
  endfunction

  // Offers one request and returns at the edge where the transfer happens.
  task automatic offer(input req_t fixed, input bit pick_random);
    req_t q;
    q = fixed;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    if (pick_random) q = random_request();
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    ins_weight     = 40;
    rem_weight     = 30;
    r              = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty store: every action fails, removing from the end reports empty.
    offer(make_req(ACT_REMOVE, 0, 1'b1, '0), 1'b0);
    offer(make_req(ACT_REMOVE, 0, 1'b0, '0), 1'b0);
    offer(make_req(ACT_READ, 0, 1'b0, '0), 1'b0);
    offer(make_req(ACT_OVERWRITE, 0, 1'b0, 32'h1234_5678), 1'b0);
    offer(make_req(ACT_INSERT, 1, 1'b0, 32'h5555_aaaa), 1'b0);

    // Fill to capacity, inserting at the end, the front and the middle.
    for (k = 0; k < DEPTH; k++) begin
      case (k)
        0:       r.value = 32'h7fff_ffff;
        1:       r.value = 32'h8000_0000;
        2:       r.value = '1;
        3:       r.value = '0;
        default: r.value = $urandom;
      endcase
      if (k % 3 == 0) offer(make_req(ACT_INSERT, 0, 1'b1, r.value), 1'b0);
      else if (k % 3 == 1) offer(make_req(ACT_INSERT, 0, 1'b0, r.value), 1'b0);
      else offer(make_req(ACT_INSERT, k / 2, 1'b0, r.value), 1'b0);
    end

    // Full store: a valid gap reports full, a gap past the count reports range.
    offer(make_req(ACT_INSERT, DEPTH, 1'b0, 32'hdead_beef), 1'b0);
    offer(make_req(ACT_INSERT, 31, 1'b0, 32'hdead_beef), 1'b0);
    offer(make_req(ACT_INSERT, 0, 1'b1, 32'hdead_beef), 1'b0);
    offer(make_req(ACT_READ, DEPTH - 1, 1'b1, '0), 1'b0);
    offer(make_req(ACT_READ, DEPTH, 1'b0, '0), 1'b0);
    offer(make_req(ACT_OVERWRITE, 0, 1'b0, 32'h8000_0000), 1'b0);
    offer(make_req(ACT_OVERWRITE, DEPTH - 1, 1'b1, 32'h7fff_ffff), 1'b0);
    offer(make_req(ACT_REMOVE, 31, 1'b0, '0), 1'b0);
    offer(make_req(ACT_REMOVE, 7, 1'b0, '0), 1'b0);
    offer(make_req(ACT_REMOVE, 0, 1'b1, '0), 1'b0);

    // The receiver holds off while requests keep coming, so the block stalls.
    pause_until_drained();
    hold_req <= ~hold_req;
    repeat (20) offer('0, 1'b1);
    pause_until_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      sent = 0;
      while (sent < PHASE_REQS) begin
        burst = $urandom_range(10, 30);
        case ($urandom_range(2))
          0:       begin ins_weight = 70; rem_weight = 10; end
          1:       begin ins_weight = 10; rem_weight = 70; end
          default: begin ins_weight = 30; rem_weight = 30; end
        endcase
        repeat (burst) offer('0, 1'b1);
        sent += burst;
      end
    end

    pause_until_drained();
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
